// ===== rtl/cau_pkg.sv =====
`timescale 1ns / 1ps
package cau_pkg;

   // operation codes of a request
   typedef enum logic [3:0] {
      CMD_ADD   = 4'd0,
      CMD_SUB   = 4'd1,
      CMD_MUL   = 4'd2,
      CMD_DIV   = 4'd3,
      CMD_ADDR  = 4'd4,
      CMD_SUBR  = 4'd5,
      CMD_SCALE = 4'd6,
      CMD_DIVR  = 4'd7,
      CMD_RDIV  = 4'd8
   } cau_cmd_type;

   // alignment of the numerator before the divider chain
   typedef enum logic [1:0] {
      SHIFT_NONE = 2'd0,
      SHIFT_UP   = 2'd1,
      SHIFT_DOWN = 2'd2
   } cau_shift_type;

   // per-request flags carried along the divider chain, lane 0 real, lane 1 imaginary
   typedef struct packed {
      logic [1:0] neg;
      logic [1:0] ovf;
      logic       zero_div;
   } cau_flags_type;

endpackage

// ===== rtl/cau_if.sv =====
`timescale 1ns / 1ps
interface cau_req_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic [3:0]                   command;
   logic signed [DATA_WIDTH-1:0] a_re;
   logic signed [DATA_WIDTH-1:0] a_im;
   logic signed [DATA_WIDTH-1:0] b_re;
   logic signed [DATA_WIDTH-1:0] b_im;

   modport source (output valid, command, a_re, a_im, b_re, b_im, input ready);
   modport sink (input valid, command, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] r_re;
   logic signed [DATA_WIDTH-1:0] r_im;
   logic                         zero_divisor;
   logic                         saturated;

   modport source (output valid, r_re, r_im, zero_divisor, saturated, input ready);
   modport sink (input valid, r_re, r_im, zero_divisor, saturated, output ready);
endinterface

// ===== rtl/cau_front.sv =====
`timescale 1ns / 1ps
module cau_front #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   cau_req_if.sink                                  req,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic [1:0][2*DATA_WIDTH-1:0]             out_rem,
   output logic [1:0][DATA_WIDTH-1:0]               out_nlo,
   output logic [2*DATA_WIDTH-1:0]                  out_div,
   output cau_pkg::cau_flags_type                   out_flags
);
   import cau_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int DW = 2 * DATA_WIDTH;
   localparam int SW = 2 * DATA_WIDTH + 2;
   localparam int NW = 2 * DATA_WIDTH + FRAC_BITS;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;

   // stage 1 registers
   logic [3:0]                 s1_cmd_ff;
   logic signed [W-1:0]        s1_a_re_ff, s1_a_im_ff, s1_b_re_ff, s1_b_im_ff;
   logic signed [DW-1:0]       s1_p_ar_br_ff, s1_p_ai_bi_ff, s1_p_ar_bi_ff, s1_p_ai_br_ff;
   logic signed [DW-1:0]       s1_p_xx_ff, s1_p_yy_ff;
   logic signed [W-1:0]        sq_x, sq_y;

   // stage 2 registers
   logic [1:0][SW-1:0]         s2_sum_ff, s2_sum_in;
   logic [DW-1:0]              s2_div_ff, s2_div_in;
   cau_shift_type              s2_shift_ff, s2_shift_in;
   logic                       s2_dneg_ff, s2_dneg_in;
   logic [W-1:0]               br_abs;
   logic [DW-1:0]              den;

   // stage 3 registers
   logic [1:0][NW-1:0]         s3_num_ff, s3_num_in;
   logic [DW-1:0]              s3_div_ff;
   logic [1:0]                 s3_neg_ff, s3_neg_in;
   logic                       s3_zd_ff, s3_zd_in;

   // stage 4 registers
   logic [1:0][DW-1:0]         s4_rem_ff, s4_rem_in;
   logic [1:0][W-1:0]          s4_nlo_ff, s4_nlo_in;
   logic [DW-1:0]              s4_div_ff;
   cau_flags_type              s4_flags_ff, s4_flags_in;

   // ready chain
   assign s4_ready  = !s4_valid_ff || out_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req.ready = s1_ready;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req.valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   // squared operand pair: divisor for complex division, a for real over complex
   assign sq_x = (req.command == CMD_RDIV) ? req.a_re : req.b_re;
   assign sq_y = (req.command == CMD_RDIV) ? req.a_im : req.b_im;

   // stage 1: partial products
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_cmd_ff     <= req.command;
         s1_a_re_ff    <= req.a_re;
         s1_a_im_ff    <= req.a_im;
         s1_b_re_ff    <= req.b_re;
         s1_b_im_ff    <= req.b_im;
         s1_p_ar_br_ff <= req.a_re * req.b_re;
         s1_p_ai_bi_ff <= req.a_im * req.b_im;
         s1_p_ar_bi_ff <= req.a_re * req.b_im;
         s1_p_ai_br_ff <= req.a_im * req.b_re;
         s1_p_xx_ff    <= sq_x * sq_x;
         s1_p_yy_ff    <= sq_y * sq_y;
      end
   end

   // stage 2: exact numerators, divisor and alignment per operation
   assign br_abs = s1_b_re_ff[W-1] ? W'(-s1_b_re_ff) : W'(s1_b_re_ff);
   assign den    = DW'(s1_p_xx_ff) + DW'(s1_p_yy_ff);

   always_comb begin
      s2_sum_in   = '0;
      s2_div_in   = DW'(1);
      s2_shift_in = SHIFT_NONE;
      s2_dneg_in  = 1'b0;
      unique case (s1_cmd_ff)
         CMD_ADD: begin
            s2_sum_in[0] = SW'(s1_a_re_ff) + SW'(s1_b_re_ff);
            s2_sum_in[1] = SW'(s1_a_im_ff) + SW'(s1_b_im_ff);
         end
         CMD_SUB: begin
            s2_sum_in[0] = SW'(s1_a_re_ff) - SW'(s1_b_re_ff);
            s2_sum_in[1] = SW'(s1_a_im_ff) - SW'(s1_b_im_ff);
         end
         CMD_MUL: begin
            s2_sum_in[0] = SW'(s1_p_ar_br_ff) - SW'(s1_p_ai_bi_ff);
            s2_sum_in[1] = SW'(s1_p_ar_bi_ff) + SW'(s1_p_ai_br_ff);
            s2_shift_in  = SHIFT_DOWN;
         end
         CMD_DIV: begin
            s2_sum_in[0] = SW'(s1_p_ar_br_ff) + SW'(s1_p_ai_bi_ff);
            s2_sum_in[1] = SW'(s1_p_ai_br_ff) - SW'(s1_p_ar_bi_ff);
            s2_div_in    = den;
            s2_shift_in  = SHIFT_UP;
         end
         CMD_ADDR: begin
            s2_sum_in[0] = SW'(s1_a_re_ff) + SW'(s1_b_re_ff);
            s2_sum_in[1] = SW'(s1_a_im_ff);
         end
         CMD_SUBR: begin
            s2_sum_in[0] = SW'(s1_a_re_ff) - SW'(s1_b_re_ff);
            s2_sum_in[1] = SW'(s1_a_im_ff);
         end
         CMD_SCALE: begin
            s2_sum_in[0] = SW'(s1_p_ar_br_ff);
            s2_sum_in[1] = SW'(s1_p_ai_br_ff);
            s2_shift_in  = SHIFT_DOWN;
         end
         CMD_DIVR: begin
            s2_sum_in[0] = SW'(s1_a_re_ff);
            s2_sum_in[1] = SW'(s1_a_im_ff);
            s2_div_in    = DW'(br_abs);
            s2_dneg_in   = s1_b_re_ff[W-1];
            s2_shift_in  = SHIFT_UP;
         end
         CMD_RDIV: begin
            s2_sum_in[0] = SW'(s1_p_ar_br_ff);
            s2_sum_in[1] = -SW'(s1_p_ai_br_ff);
            s2_div_in    = den;
            s2_shift_in  = SHIFT_UP;
         end
         default: begin
            s2_sum_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_sum_ff   <= s2_sum_in;
         s2_div_ff   <= s2_div_in;
         s2_shift_ff <= s2_shift_in;
         s2_dneg_ff  <= s2_dneg_in;
      end
   end

   // stage 3: sign and magnitude, fraction alignment
   always_comb begin
      logic [SW-1:0] mag;
      s3_num_in = '0;
      s3_neg_in = '0;
      for (int l = 0; l < 2; l++) begin
         mag          = s2_sum_ff[l][SW-1] ? -s2_sum_ff[l] : s2_sum_ff[l];
         s3_neg_in[l] = s2_sum_ff[l][SW-1] ^ s2_dneg_ff;
         unique case (s2_shift_ff)
            SHIFT_UP:   s3_num_in[l] = NW'(mag[DW-1:0]) << FRAC_BITS;
            SHIFT_DOWN: s3_num_in[l] = NW'(mag[DW-1:0] >> FRAC_BITS);
            SHIFT_NONE: s3_num_in[l] = NW'(mag[DW-1:0]);
            default:    s3_num_in[l] = '0;
         endcase
      end
      s3_zd_in = (s2_shift_ff == SHIFT_UP) && (s2_div_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_num_ff <= s3_num_in;
         s3_div_ff <= s2_div_ff;
         s3_neg_ff <= s3_neg_in;
         s3_zd_ff  <= s3_zd_in;
      end
   end

   // stage 4: quotient range check and first partial remainder
   always_comb begin
      logic [NW-1:0] upper;
      s4_rem_in = '0;
      s4_nlo_in = '0;
      s4_flags_in.neg      = s3_neg_ff;
      s4_flags_in.zero_div = s3_zd_ff;
      s4_flags_in.ovf      = '0;
      for (int l = 0; l < 2; l++) begin
         upper              = s3_num_ff[l] >> W;
         s4_flags_in.ovf[l] = upper >= NW'(s3_div_ff);
         s4_rem_in[l]       = upper[DW-1:0];
         s4_nlo_in[l]       = s3_num_ff[l][W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_rem_ff   <= s4_rem_in;
         s4_nlo_ff   <= s4_nlo_in;
         s4_div_ff   <= s3_div_ff;
         s4_flags_ff <= s4_flags_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_rem   = s4_rem_ff;
   assign out_nlo   = s4_nlo_ff;
   assign out_div   = s4_div_ff;
   assign out_flags = s4_flags_ff;

endmodule

// ===== rtl/cau_div_cell.sv =====
`timescale 1ns / 1ps
module cau_div_cell #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [1:0][2*DATA_WIDTH-1:0]      in_rem,
   input  logic [1:0][DATA_WIDTH-1:0]        in_nlo,
   input  logic [1:0][DATA_WIDTH-1:0]        in_quo,
   input  logic [2*DATA_WIDTH-1:0]           in_div,
   input  cau_pkg::cau_flags_type            in_flags,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [1:0][2*DATA_WIDTH-1:0]      out_rem,
   output logic [1:0][DATA_WIDTH-1:0]        out_nlo,
   output logic [1:0][DATA_WIDTH-1:0]        out_quo,
   output logic [2*DATA_WIDTH-1:0]           out_div,
   output cau_pkg::cau_flags_type            out_flags
);
   import cau_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int DW = 2 * DATA_WIDTH;

   logic                valid_ff;
   logic [1:0][DW-1:0]  rem_ff, rem_in;
   logic [1:0][W-1:0]   nlo_ff, nlo_in;
   logic [1:0][W-1:0]   quo_ff, quo_in;
   logic [DW-1:0]       div_ff;
   cau_flags_type       flags_ff;

   assign in_ready = !valid_ff || out_ready;

   // one restoring step per lane: bring in the next numerator bit, try subtract
   always_comb begin
      logic [DW:0] trial;
      logic        take;
      for (int l = 0; l < 2; l++) begin
         trial     = {in_rem[l], in_nlo[l][W-1]};
         take      = trial >= {1'b0, in_div};
         rem_in[l] = take ? DW'(trial - {1'b0, in_div}) : trial[DW-1:0];
         nlo_in[l] = in_nlo[l] << 1;
         quo_in[l] = {in_quo[l][W-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff   <= rem_in;
         nlo_ff   <= nlo_in;
         quo_ff   <= quo_in;
         div_ff   <= in_div;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_nlo   = nlo_ff;
   assign out_quo   = quo_ff;
   assign out_div   = div_ff;
   assign out_flags = flags_ff;

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// throughput: one request per cycle unless the response stalls; four front stages,
//   then one divider cell per quotient bit, then the saturating output register
// every operation runs through the same divider chain, non-dividing ones by one
// reset: synchronous, active high, clears all valid bits; the data path is not reset
`timescale 1ns / 1ps
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic   clock,
   input  logic   reset,
   cau_req_if.sink   req_bus,
   cau_rsp_if.source rsp_bus
);
   import cau_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int DW = 2 * DATA_WIDTH;

   logic               c_valid [W+1];
   logic               c_ready [W+1];
   logic [1:0][DW-1:0] c_rem   [W+1];
   logic [1:0][W-1:0]  c_nlo   [W+1];
   logic [1:0][W-1:0]  c_quo   [W+1];
   logic [DW-1:0]      c_div   [W+1];
   cau_flags_type      c_flags [W+1];

   logic                   rsp_valid_ff;
   logic [1:0][W-1:0]      res_ff, res_in;
   logic                   zd_ff, zd_in;
   logic                   sat_ff, sat_in;
   logic                   out_ready;

   // operand products, numerators and divisor
   cau_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .out_valid (c_valid[0]),
      .out_ready (c_ready[0]),
      .out_rem   (c_rem[0]),
      .out_nlo   (c_nlo[0]),
      .out_div   (c_div[0]),
      .out_flags (c_flags[0])
   );

   assign c_quo[0] = '0;

   // divider chain, one quotient bit per cell
   for (genvar i = 0; i < W; i++) begin : g_cell
      cau_div_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[i]),
         .in_ready  (c_ready[i]),
         .in_rem    (c_rem[i]),
         .in_nlo    (c_nlo[i]),
         .in_quo    (c_quo[i]),
         .in_div    (c_div[i]),
         .in_flags  (c_flags[i]),
         .out_valid (c_valid[i+1]),
         .out_ready (c_ready[i+1]),
         .out_rem   (c_rem[i+1]),
         .out_nlo   (c_nlo[i+1]),
         .out_quo   (c_quo[i+1]),
         .out_div   (c_div[i+1]),
         .out_flags (c_flags[i+1])
      );
   end

   assign out_ready   = !rsp_valid_ff || rsp_bus.ready;
   assign c_ready[W]  = out_ready;

   // saturation, sign and zero divisor override
   always_comb begin
      logic [W-1:0] lim;
      logic [W-1:0] mag;
      logic         clip;
      res_in = '0;
      sat_in = 1'b0;
      zd_in  = c_flags[W].zero_div;
      for (int l = 0; l < 2; l++) begin
         lim = c_flags[W].neg[l] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         clip = c_flags[W].ovf[l] || (c_quo[W][l] > lim);
         mag = clip ? lim : c_quo[W][l];
         res_in[l] = c_flags[W].neg[l] ? -mag : mag;
         sat_in = sat_in | clip;
      end
      if (c_flags[W].zero_div) begin
         res_in = '0;
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= c_valid[W];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         res_ff <= res_in;
         zd_ff  <= zd_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.r_re         = res_ff[0];
   assign rsp_bus.r_im         = res_ff[1];
   assign rsp_bus.zero_divisor = zd_ff;
   assign rsp_bus.saturated    = sat_ff;

endmodule

// ===== rtl/cau_checker.sv =====
`timescale 1ns / 1ps
module cau_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_r_re,
   input logic [DATA_WIDTH-1:0] rsp_r_im,
   input logic                  rsp_zero_divisor,
   input logic                  rsp_saturated
);

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_r_re) && $stable(rsp_r_im))
      else $error("stalled response changed");

   // a zero divisor never reports clipping
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_zero_divisor && rsp_saturated))
      else $error("zero divisor with saturation");

   // a zero divisor gives a zero result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_divisor |-> rsp_r_re == '0 && rsp_r_im == '0)
      else $error("zero divisor with nonzero result");

   // no response in the first cycle out of reset
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind complex_arithmetic_unit cau_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_cau_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_r_re         (rsp_bus.r_re),
   .rsp_r_im         (rsp_bus.r_im),
   .rsp_zero_divisor (rsp_bus.zero_divisor),
   .rsp_saturated    (rsp_bus.saturated)
);

// ===== tb/complex_arithmetic_unit_tb.sv =====
`timescale 1ns / 1ps
module complex_arithmetic_unit_tb;
   import cau_pkg::*;

   localparam int DW = 32;
   localparam int FB = 16;
   localparam int FLUSH_CYCLES = DW + 10;
   localparam logic signed [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [DW-1:0] ONE = 1 <<< FB;

   typedef logic signed [199:0] wide_type;

   typedef struct {
      logic signed [DW-1:0] r_re;
      logic signed [DW-1:0] r_im;
      logic                 zero_divisor;
      logic                 saturated;
   } cau_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   failed = 1'b0;
   bit   no_idle = 1'b0;
   cau_result_type expected_results[$];

   cau_req_if #(.DATA_WIDTH(DW)) req_bus ();
   cau_rsp_if #(.DATA_WIDTH(DW)) rsp_bus ();

   complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #2 clock = ~clock;

   // clip one exact part to the word range
   function automatic logic signed [DW-1:0] clip_part(wide_type v, inout logic sat);
      if (v > wide_type'(WORD_MAX)) begin
         sat = 1'b1;
         return WORD_MAX;
      end
      if (v < wide_type'(WORD_MIN)) begin
         sat = 1'b1;
         return WORD_MIN;
      end
      return v[DW-1:0];
   endfunction

   // exact complex arithmetic, truncated toward zero, then saturated
   function automatic cau_result_type compute_complex(logic [3:0] cmd,
         logic signed [DW-1:0] a_re, logic signed [DW-1:0] a_im,
         logic signed [DW-1:0] b_re, logic signed [DW-1:0] b_im);
      wide_type ar, ai, br, bi, pr, pi, den, scale;
      cau_result_type res;
      logic sat, zd;
      ar = a_re;
      ai = a_im;
      br = b_re;
      bi = b_im;
      pr = '0;
      pi = '0;
      sat = 1'b0;
      zd = 1'b0;
      scale = wide_type'(1) <<< FB;
      case (cmd)
         CMD_ADD: begin
            pr = ar + br;
            pi = ai + bi;
         end
         CMD_SUB: begin
            pr = ar - br;
            pi = ai - bi;
         end
         CMD_MUL: begin
            pr = (ar * br - ai * bi) / scale;
            pi = (ar * bi + ai * br) / scale;
         end
         CMD_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) zd = 1'b1;
            else begin
               pr = ((ar * br + ai * bi) * scale) / den;
               pi = ((ai * br - ar * bi) * scale) / den;
            end
         end
         CMD_ADDR: begin
            pr = ar + br;
            pi = ai;
         end
         CMD_SUBR: begin
            pr = ar - br;
            pi = ai;
         end
         CMD_SCALE: begin
            pr = (ar * br) / scale;
            pi = (ai * br) / scale;
         end
         CMD_DIVR: begin
            if (br == 0) zd = 1'b1;
            else begin
               pr = (ar * scale) / br;
               pi = (ai * scale) / br;
            end
         end
         CMD_RDIV: begin
            den = ar * ar + ai * ai;
            if (den == 0) zd = 1'b1;
            else begin
               pr = ((ar * br) * scale) / den;
               pi = -(((ai * br) * scale) / den);
            end
         end
         default: ;
      endcase
      res.r_re = clip_part(pr, sat);
      res.r_im = clip_part(pi, sat);
      res.zero_divisor = zd;
      res.saturated = sat;
      return res;
   endfunction

   // send one request, random idle gap in front
   task automatic send_request(logic [3:0] cmd, logic signed [DW-1:0] a_re,
         logic signed [DW-1:0] a_im, logic signed [DW-1:0] b_re,
         logic signed [DW-1:0] b_im);
      while (!no_idle && $urandom_range(99) < 16) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.a_re <= a_re;
      req_bus.a_im <= a_im;
      req_bus.b_re <= b_re;
      req_bus.b_im <= b_im;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_results.push_back(compute_complex(cmd, a_re, a_im, b_re, b_im));
   endtask

   // operand part: full range, small, zero, an extreme or plus or minus ONE
   function automatic logic signed [DW-1:0] random_part();
      case ($urandom_range(9))
         0, 1, 2: return $urandom;
         3, 4, 5: return $signed($urandom_range(2 * ONE * 64)) - ONE * 64;
         6:       return $signed($urandom_range(511)) - 256;
         7:       return '0;
         8:       return ($urandom_range(1) != 0) ? WORD_MAX : WORD_MIN;
         default: return ($urandom_range(1) != 0) ? ONE : -ONE;
      endcase
   endfunction

   function automatic logic [3:0] random_command();
      if ($urandom_range(19) == 0) return 4'($urandom_range(15, 9));
      return 4'($urandom_range(8));
   endfunction

   // result ready, stalls at random
   always @(posedge clock) begin
      if (reset || no_idle) rsp_bus.ready <= 1'b1;
      else rsp_bus.ready <= ($urandom_range(99) >= 16);
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      cau_result_type exp_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result re=%h im=%h", $realtime, rsp_bus.r_re,
                     rsp_bus.r_im);
            failed = 1'b1;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_bus.r_re !== exp_r.r_re) begin
               $display("%0t: r_re expected %h actual %h", $realtime, exp_r.r_re,
                        rsp_bus.r_re);
               failed = 1'b1;
            end
            if (rsp_bus.r_im !== exp_r.r_im) begin
               $display("%0t: r_im expected %h actual %h", $realtime, exp_r.r_im,
                        rsp_bus.r_im);
               failed = 1'b1;
            end
            if (rsp_bus.zero_divisor !== exp_r.zero_divisor) begin
               $display("%0t: zero_divisor expected %b actual %b", $realtime,
                        exp_r.zero_divisor, rsp_bus.zero_divisor);
               failed = 1'b1;
            end
            if (rsp_bus.saturated !== exp_r.saturated) begin
               $display("%0t: saturated expected %b actual %b", $realtime,
                        exp_r.saturated, rsp_bus.saturated);
               failed = 1'b1;
            end
         end
      end
   end

   // every command, extremes, zero divisors, saturation, unused codes
   task automatic test_directed();
      send_request(CMD_ADD, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
      send_request(CMD_ADD, ONE, -ONE, 3 * ONE, 5);
      send_request(CMD_SUB, WORD_MIN, WORD_MAX, ONE, -ONE);
      send_request(CMD_SUB, 7 * ONE, 2 * ONE, 3 * ONE, 9 * ONE);
      send_request(CMD_MUL, 2 * ONE, 3 * ONE, 4 * ONE, -5 * ONE);
      send_request(CMD_MUL, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN);
      send_request(CMD_MUL, -3, 1, 1, 0);
      send_request(CMD_DIV, 1 * ONE, 2 * ONE, 3 * ONE, 4 * ONE);
      send_request(CMD_DIV, ONE, ONE, 0, 0);
      send_request(CMD_DIV, WORD_MAX, WORD_MIN, 1, 0);
      send_request(CMD_ADDR, WORD_MAX, -ONE, ONE, WORD_MIN);
      send_request(CMD_SUBR, WORD_MIN, ONE, ONE, WORD_MAX);
      send_request(CMD_SCALE, 3 * ONE, -2 * ONE, -ONE / 2, 12345);
      send_request(CMD_SCALE, WORD_MIN, WORD_MAX, WORD_MIN, 0);
      send_request(CMD_DIVR, 5 * ONE, -7 * ONE, 2 * ONE, -1);
      send_request(CMD_DIVR, ONE, ONE, 0, ONE);
      send_request(CMD_DIVR, WORD_MIN, WORD_MAX, -1, 0);
      send_request(CMD_RDIV, 3 * ONE, 4 * ONE, 25 * ONE, 0);
      send_request(CMD_RDIV, 0, 0, ONE, ONE);
      send_request(CMD_RDIV, 1, 0, WORD_MAX, 0);
      send_request(4'd9, ONE, ONE, ONE, ONE);
      send_request(4'd15, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
   endtask

   // random operations with both sides idling
   task automatic test_random(int count);
      repeat (count) begin
         send_request(random_command(), random_part(), random_part(), random_part(),
                      random_part());
      end
   endtask

   // back-to-back requests with no stalls on either side
   task automatic test_streaming(int count);
      no_idle = 1'b1;
      test_random(count);
      no_idle = 1'b0;
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.command = '0;
      req_bus.a_re = '0;
      req_bus.a_im = '0;
      req_bus.b_re = '0;
      req_bus.b_im = '0;
      rsp_bus.ready = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300);
      test_streaming(150);
      test_random(150);
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
      if (!failed) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #400000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/cau_pkg.sv
rtl/cau_if.sv
rtl/cau_front.sv
rtl/cau_div_cell.sv
rtl/complex_arithmetic_unit.sv
rtl/cau_checker.sv
tb/complex_arithmetic_unit_tb.sv
